FILE: sv/fdmt_pkg.sv
// shared types and constants for the frame difference motion trigger
// no dependencies; imported by every module of the block
package fdmt_pkg;

  localparam int unsigned MAX_FRAME_PIXELS = 2097152;
  localparam int CNT_W      = $clog2(MAX_FRAME_PIXELS + 1);
  localparam int PIX_W      = 8;
  localparam int RATE_W     = 15;
  localparam int CD_W       = 17;
  localparam int TALLY_W    = 24;
  localparam int PHASE_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // gray conversion of the channel differences
  localparam int GRAY_SUM_W = 22;
  localparam int GRAY_SHIFT = 14;
  localparam logic [GRAY_SUM_W-1:0] COEF_B     = 22'd1868;
  localparam logic [GRAY_SUM_W-1:0] COEF_G     = 22'd9617;
  localparam logic [GRAY_SUM_W-1:0] COEF_R     = 22'd4899;
  localparam logic [GRAY_SUM_W-1:0] GRAY_ROUND = 22'd8192;

  // share in hundredths of a percent
  localparam int SCALE_W   = 14;
  localparam int PROD_W    = CNT_W + SCALE_W;
  localparam int DIV_STEPS = SCALE_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam logic [SCALE_W-1:0] RATE_SCALE = 14'd10000;
  localparam logic signed [RATE_W-1:0] RATE_INVALID = -15'sd100;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PIXEL_THRESHOLD,
    CFG_RATE_LOWER,
    CFG_RATE_UPPER,
    CFG_DIFF_INTERVAL,
    CFG_FRAMES_AFTER,
    CFG_MAX_FRAMES
  } cfg_idx_e;

  typedef struct packed {
    logic [PIX_W-1:0]          pixel_threshold;
    logic signed [RATE_W-1:0]  rate_lower;
    logic signed [RATE_W-1:0]  rate_upper;
    logic [PHASE_W-1:0]        diff_interval;
    logic [CD_W-2:0]           frames_after;
    logic [TALLY_W-1:0]        max_frames;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] changed;
    logic [CNT_W-1:0] pixels;
    logic             missing;
  } frame_sum_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_UPD
  } back_state_e;

endpackage

FILE: sv/fdmt_front.sv
// pixel front end: channel differences, gray threshold and per-frame counting
// depends on fdmt_pkg; hands one frame summary per last pixel to the queue
module fdmt_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [7:0]              cur_blue_i,
  input  logic [7:0]              cur_green_i,
  input  logic [7:0]              cur_red_i,
  input  logic [7:0]              old_blue_i,
  input  logic [7:0]              old_green_i,
  input  logic [7:0]              old_red_i,
  input  logic                    old_valid_i,
  input  logic                    last_pixel_i,
  input  logic [7:0]              threshold_i,
  output logic                    push_valid_o,
  input  logic                    push_ready_i,
  output fdmt_pkg::frame_sum_t    push_data_o
);
  import fdmt_pkg::*;

  function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  logic             a_valid_q;
  logic [PIX_W-1:0] db_q, dg_q, dr_q;
  logic             ok_q, last_q;

  logic [CNT_W-1:0] pixels_q, pixels_nx;
  logic [CNT_W-1:0] changed_q, changed_nx;
  logic             missing_q, missing_nx;

  logic [GRAY_SUM_W-1:0] gray_sum;
  logic [PIX_W-1:0]      gray;
  logic                  px_changed, pix_inc, consume;

  assign gray_sum = GRAY_SUM_W'(db_q) * COEF_B + GRAY_SUM_W'(dg_q) * COEF_G
                  + GRAY_SUM_W'(dr_q) * COEF_R + GRAY_ROUND;
  assign gray       = gray_sum[GRAY_SUM_W-1:GRAY_SHIFT];
  assign px_changed = gray > threshold_i;

  // counts stop at the frame size limit
  assign pix_inc    = pixels_q < CNT_W'(MAX_FRAME_PIXELS);
  assign pixels_nx  = pix_inc ? pixels_q + 1'b1 : pixels_q;
  assign changed_nx = (pix_inc && px_changed) ? changed_q + 1'b1 : changed_q;
  assign missing_nx = missing_q | ~ok_q;

  assign consume      = a_valid_q && (!last_q || push_ready_i);
  assign in_ready_o   = !a_valid_q || consume;
  assign push_valid_o = a_valid_q && last_q;
  assign push_data_o  = '{changed: changed_nx, pixels: pixels_nx, missing: missing_nx};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      db_q   <= abs_diff(cur_blue_i, old_blue_i);
      dg_q   <= abs_diff(cur_green_i, old_green_i);
      dr_q   <= abs_diff(cur_red_i, old_red_i);
      ok_q   <= old_valid_i;
      last_q <= last_pixel_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixels_q  <= '0;
      changed_q <= '0;
      missing_q <= 1'b0;
    end else if (consume) begin
      if (last_q) begin
        pixels_q  <= '0;
        changed_q <= '0;
        missing_q <= 1'b0;
      end else begin
        pixels_q  <= pixels_nx;
        changed_q <= changed_nx;
        missing_q <= missing_nx;
      end
    end
  end

endmodule

FILE: sv/fdmt_queue.sv
// two-entry queue of frame summaries between the front end and the back end
// depends on fdmt_pkg for the summary type and depth
module fdmt_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  fdmt_pkg::frame_sum_t push_data_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output fdmt_pkg::frame_sum_t pop_data_o
);
  import fdmt_pkg::*;

  frame_sum_t        mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign push_ready_o = cnt_q != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= QPTR_W'((32'(wr_ptr_q) + 1) % QUEUE_DEPTH);
      end
      if (do_pop) begin
        rd_ptr_q <= QPTR_W'((32'(rd_ptr_q) + 1) % QUEUE_DEPTH);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

FILE: sv/fdmt_back.sv
// frame back end: share by multiply and restoring divide, record trigger,
// cooldown and frame cap, output register; depends on fdmt_pkg
module fdmt_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fdmt_pkg::cfg_t                cfg_i,
  input  logic                          pop_valid_i,
  output logic                          pop_ready_o,
  input  fdmt_pkg::frame_sum_t          pop_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [14:0]            change_rate_o,
  output logic                          recording_o,
  output logic                          record_started_o,
  output logic                          record_ended_o,
  output logic signed [16:0]            cooldown_left_o,
  output logic [23:0]                   video_frames_o
);
  import fdmt_pkg::*;

  back_state_e state_q, state_d;
  frame_sum_t  sum_q, sum_d;

  logic [PHASE_W-1:0]       phase_q, phase_d;
  logic signed [RATE_W-1:0] held_q, held_d;
  logic signed [CD_W-1:0]   cd_q, cd_d;
  logic [TALLY_W-1:0]       tally_q, tally_d;
  logic                     rec_q, rec_d;

  logic [CNT_W-1:0]   rem_q, rem_d;
  logic [SCALE_W-1:0] dq_q, dq_d;
  logic [STEP_W-1:0]  step_q, step_d;

  logic                     out_valid_q, out_valid_d;
  logic signed [RATE_W-1:0] out_rate_q, out_rate_d;
  logic                     out_rec_q, out_rec_d;
  logic                     out_start_q, out_start_d;
  logic                     out_end_q, out_end_d;
  logic signed [CD_W-1:0]   out_cd_q, out_cd_d;
  logic [TALLY_W-1:0]       out_tally_q, out_tally_d;

  // phase advance
  logic [PHASE_W-1:0] interval;
  logic [PHASE_W:0]   phase_inc;
  logic [PHASE_W-1:0] phase_nx;

  // divide step
  logic [PROD_W-1:0] prod;
  logic [CNT_W:0]    trial, trial_diff;
  logic              trial_ge;

  // frame update
  logic                   trig, started, ended, rec_a, rec_b;
  logic signed [CD_W-1:0] cd_a, cd_b;
  logic [TALLY_W-1:0]     tally_a, tally_b;

  assign interval  = (cfg_i.diff_interval == '0) ? PHASE_W'(1) : cfg_i.diff_interval;
  assign phase_inc = {1'b0, phase_q} + 1'b1;
  assign phase_nx  = (phase_inc >= {1'b0, interval}) ? '0 : phase_inc[PHASE_W-1:0];

  assign prod       = PROD_W'(sum_q.changed) * PROD_W'(RATE_SCALE);
  assign trial      = {rem_q, dq_q[SCALE_W-1]};
  assign trial_ge   = trial >= {1'b0, sum_q.pixels};
  assign trial_diff = trial - {1'b0, sum_q.pixels};

  always_comb begin
    trig    = (held_q > cfg_i.rate_lower) && (held_q < cfg_i.rate_upper);
    cd_a    = trig ? $signed({1'b0, cfg_i.frames_after}) : cd_q;
    started = trig && !rec_q;
    rec_a   = rec_q || trig;
    cd_b    = cd_a;
    tally_a = tally_q;
    if (!cd_a[CD_W-1]) begin
      cd_b = cd_a - 17'sd1;
      if (cd_b > 17'sd0) begin
        tally_a = tally_q + 1'b1;
      end
    end
    if (tally_a >= cfg_i.max_frames) begin
      cd_b = '0;
    end
    ended   = 1'b0;
    rec_b   = rec_a;
    tally_b = tally_a;
    if (cd_b == '0) begin
      ended   = rec_a;
      rec_b   = 1'b0;
      tally_b = '0;
    end
  end

  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    phase_d     = phase_q;
    held_d      = held_q;
    cd_d        = cd_q;
    tally_d     = tally_q;
    rec_d       = rec_q;
    rem_d       = rem_q;
    dq_d        = dq_q;
    step_d      = step_q;
    out_rate_d  = out_rate_q;
    out_rec_d   = out_rec_q;
    out_start_d = out_start_q;
    out_end_d   = out_end_q;
    out_cd_d    = out_cd_q;
    out_tally_d = out_tally_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pop_ready_o = 1'b0;
    case (state_q)
      BK_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          sum_d   = pop_data_i;
          phase_d = phase_nx;
          if (phase_q != '0) begin
            state_d = BK_UPD;
          end else if (pop_data_i.missing) begin
            held_d  = RATE_INVALID;
            state_d = BK_UPD;
          end else begin
            state_d = BK_MUL;
          end
        end
      end
      BK_MUL: begin
        // quotient fits the scale width, so the upper half is below the divisor
        rem_d   = prod[PROD_W-1:SCALE_W];
        dq_d    = prod[SCALE_W-1:0];
        step_d  = '0;
        state_d = BK_DIV;
      end
      BK_DIV: begin
        rem_d  = trial_ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
        dq_d   = {dq_q[SCALE_W-2:0], trial_ge};
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          held_d  = $signed({1'b0, dq_d});
          state_d = BK_UPD;
        end
      end
      BK_UPD: begin
        if (!out_valid_q || out_ready_i) begin
          cd_d        = cd_b;
          tally_d     = tally_b;
          rec_d       = rec_b;
          out_valid_d = 1'b1;
          out_rate_d  = held_q;
          out_rec_d   = rec_b;
          out_start_d = started;
          out_end_d   = ended;
          out_cd_d    = cd_b;
          out_tally_d = tally_b;
          state_d     = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      phase_q     <= '0;
      held_q      <= '0;
      cd_q        <= '0;
      tally_q     <= '0;
      rec_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      held_q      <= held_d;
      cd_q        <= cd_d;
      tally_q     <= tally_d;
      rec_q       <= rec_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q       <= sum_d;
    rem_q       <= rem_d;
    dq_q        <= dq_d;
    step_q      <= step_d;
    out_rate_q  <= out_rate_d;
    out_rec_q   <= out_rec_d;
    out_start_q <= out_start_d;
    out_end_q   <= out_end_d;
    out_cd_q    <= out_cd_d;
    out_tally_q <= out_tally_d;
  end

  assign out_valid_o      = out_valid_q;
  assign change_rate_o    = out_rate_q;
  assign recording_o      = out_rec_q;
  assign record_started_o = out_start_q;
  assign record_ended_o   = out_end_q;
  assign cooldown_left_o  = out_cd_q;
  assign video_frames_o   = out_tally_q;

`ifndef SYNTHESIS
  a_start_sets_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_start_q |-> out_rec_q || out_end_q)
    else $error("start flagged without recording");
  a_end_clears_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_end_q |-> !out_rec_q)
    else $error("end flagged while still recording");
  a_idle_no_tally: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_rec_q |-> out_tally_q == '0)
    else $error("frame tally kept outside a recording");
  a_pop_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_valid_i && pop_ready_o |=> state_q != BK_IDLE)
    else $error("summary popped but back end stayed idle");
`endif

endmodule

FILE: sv/frame_difference_motion_trigger.sv
// top level of the frame difference motion trigger: register file, front end,
// summary queue and back end; depends on fdmt_pkg, fdmt_front, fdmt_queue, fdmt_back
//
//   channel  | handshake                 | beat carries
//   ---------+---------------------------+---------------------------------------
//   cfg      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//   in       | in_valid_i / in_ready_o   | current and previous bgr pixel, flags
//   out      | out_valid_o / out_ready_i | share, recording flags, cooldown, tally
//
// the front end takes one pixel per cycle; each last pixel sends a frame summary
// into a two-entry queue. the back end handles each frame end in the states pop,
// multiply, 14 restoring divide steps and update, or pop and update when no share
// is computed. short frames fill the queue and stall in_ready_o, as does a stalled
// output once the queue fills. reset is asynchronous and needs no clearing pass.
module frame_difference_motion_trigger (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [23:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          cur_blue_i,
  input  logic [7:0]          cur_green_i,
  input  logic [7:0]          cur_red_i,
  input  logic [7:0]          old_blue_i,
  input  logic [7:0]          old_green_i,
  input  logic [7:0]          old_red_i,
  input  logic                old_valid_i,
  input  logic                last_pixel_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [14:0]  change_rate_o,
  output logic                recording_o,
  output logic                record_started_o,
  output logic                record_ended_o,
  output logic signed [16:0]  cooldown_left_o,
  output logic [23:0]         video_frames_o
);
  import fdmt_pkg::*;

  cfg_t       cfg_q;
  frame_sum_t push_data, pop_data;
  logic       push_valid, push_ready, pop_valid, pop_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_threshold <= 8'd30;
      cfg_q.rate_lower      <= 15'sd0;
      cfg_q.rate_upper      <= 15'sd10000;
      cfg_q.diff_interval   <= 16'd1;
      cfg_q.frames_after    <= 16'd64;
      cfg_q.max_frames      <= 24'd65536;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PIXEL_THRESHOLD: cfg_q.pixel_threshold <= cfg_data_i[PIX_W-1:0];
        CFG_RATE_LOWER:      cfg_q.rate_lower      <= $signed(cfg_data_i[RATE_W-1:0]);
        CFG_RATE_UPPER:      cfg_q.rate_upper      <= $signed(cfg_data_i[RATE_W-1:0]);
        CFG_DIFF_INTERVAL:   cfg_q.diff_interval   <= cfg_data_i[PHASE_W-1:0];
        CFG_FRAMES_AFTER:    cfg_q.frames_after    <= cfg_data_i[CD_W-2:0];
        CFG_MAX_FRAMES:      cfg_q.max_frames      <= cfg_data_i[TALLY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fdmt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cur_blue_i   (cur_blue_i),
    .cur_green_i  (cur_green_i),
    .cur_red_i    (cur_red_i),
    .old_blue_i   (old_blue_i),
    .old_green_i  (old_green_i),
    .old_red_i    (old_red_i),
    .old_valid_i  (old_valid_i),
    .last_pixel_i (last_pixel_i),
    .threshold_i  (cfg_q.pixel_threshold),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  fdmt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  fdmt_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .pop_valid_i      (pop_valid),
    .pop_ready_o      (pop_ready),
    .pop_data_i       (pop_data),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .change_rate_o    (change_rate_o),
    .recording_o      (recording_o),
    .record_started_o (record_started_o),
    .record_ended_o   (record_ended_o),
    .cooldown_left_o  (cooldown_left_o),
    .video_frames_o   (video_frames_o)
  );

endmodule

FILE: verif/tb_frame_difference_motion_trigger.sv
// testbench for frame_difference_motion_trigger: directed table, then random frames,
// every frame-end beat checked against a table result or an in-bench model of the trigger
// depends on fdmt_pkg and the rtl top level only
module tb_frame_difference_motion_trigger;
  import fdmt_pkg::*;

  localparam int unsigned RAND_ITEMS       = 1950;
  localparam int unsigned RAND_PHASES      = 8;
  localparam int unsigned SETTLE_CYCLES    = 64;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam longint      CYCLE_LIMIT      = 12_000_000;
  // indexes past the register file, writes are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [PIX_W-1:0] cur_b, cur_g, cur_r;
    logic [PIX_W-1:0] old_b, old_g, old_r;
    logic             old_ok;
    logic             last;
  } pixel_t;

  typedef struct packed {
    logic signed [RATE_W-1:0] rate;
    logic                     rec;
    logic                     started;
    logic                     ended;
    logic signed [CD_W-1:0]   cooldown;
    logic [TALLY_W-1:0]       frames;
  } frame_res_t;

  typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    pixel_t                pix;
    int unsigned           reps;
    bit                    typed;
    frame_res_t            res;
  } stim_row_t;

  typedef struct {
    logic [PIX_W-1:0]   thr;
    int                 lower;
    int                 upper;
    logic [PHASE_W-1:0] interval;
    logic [15:0]        hold_frames;
    logic [TALLY_W-1:0] max_frames;
  } trigger_cfg_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic [PIX_W-1:0] cur_blue_i = '0, cur_green_i = '0, cur_red_i = '0;
  logic [PIX_W-1:0] old_blue_i = '0, old_green_i = '0, old_red_i = '0;
  logic old_valid_i = 1'b0;
  logic last_pixel_i = 1'b0;
  logic out_ready_i = 1'b0;
  logic cfg_ready_o, in_ready_o, out_valid_o;
  logic signed [RATE_W-1:0] change_rate_o;
  logic recording_o, record_started_o, record_ended_o;
  logic signed [CD_W-1:0] cooldown_left_o;
  logic [TALLY_W-1:0] video_frames_o;

  frame_difference_motion_trigger uut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o,
    .cur_blue_i, .cur_green_i, .cur_red_i,
    .old_blue_i, .old_green_i, .old_red_i,
    .old_valid_i, .last_pixel_i,
    .out_valid_o, .out_ready_i,
    .change_rate_o, .recording_o, .record_started_o, .record_ended_o,
    .cooldown_left_o, .video_frames_o
  );

  always #5 clk_i = ~clk_i;

  // model of the trigger: register copies at their reset values, then frame state
  int unsigned cfg_thr = 30, cfg_interval = 1, cfg_hold = 64, cfg_max = 65536;
  int          cfg_lower = 0, cfg_upper = 10000;
  int unsigned cnt_changed = 0, cnt_pixels = 0, share_phase = 0, video_tally = 0;
  bit          miss_prev = 1'b0, rec_on = 1'b0;
  int          rate_hold = 0, cooldown_ctr = 0;

  frame_res_t expected_frames[$];
  int unsigned fail_count = 0, pixels_sent = 0, frames_checked = 0;
  int unsigned starts_seen = 0, ends_seen = 0, reg_writes = 0;
  longint      cycle_count = 0;
  bit          calm = 1'b0;
  bit          long_hold_req = 1'b0;

  task automatic track_pixel(input pixel_t p, output bit has_frame, output frame_res_t res);
    int unsigned d_b, d_g, d_r, gray, span;
    bit started, ended;
    d_b = (p.cur_b > p.old_b) ? p.cur_b - p.old_b : p.old_b - p.cur_b;
    d_g = (p.cur_g > p.old_g) ? p.cur_g - p.old_g : p.old_g - p.cur_g;
    d_r = (p.cur_r > p.old_r) ? p.cur_r - p.old_r : p.old_r - p.cur_r;
    gray = (1868 * d_b + 9617 * d_g + 4899 * d_r + 8192) >> 14;
    has_frame = 1'b0;
    res = '0;
    started = 1'b0;
    ended = 1'b0;
    // counts stop at the frame size limit
    if (cnt_pixels < MAX_FRAME_PIXELS) begin
      cnt_pixels++;
      if (gray > cfg_thr) cnt_changed++;
    end
    if (!p.old_ok) miss_prev = 1'b1;
    if (p.last) begin
      if (share_phase == 0) begin
        if (miss_prev || cnt_pixels == 0) rate_hold = -100;
        else rate_hold = int'((longint'(cnt_changed) * 10000) / longint'(cnt_pixels));
      end
      span = (cfg_interval == 0) ? 1 : cfg_interval;
      share_phase = (share_phase + 1 >= span) ? 0 : share_phase + 1;
      cnt_changed = 0;
      cnt_pixels = 0;
      miss_prev = 1'b0;
      if (rate_hold > cfg_lower && rate_hold < cfg_upper) begin
        cooldown_ctr = int'(cfg_hold);
        if (!rec_on) begin
          rec_on = 1'b1;
          started = 1'b1;
        end
      end
      if (cooldown_ctr >= 0) begin
        cooldown_ctr--;
        if (cooldown_ctr > 0) video_tally = (video_tally + 1) & 32'hFF_FFFF;
      end
      if (video_tally >= cfg_max) cooldown_ctr = 0;
      if (cooldown_ctr == 0) begin
        if (rec_on) begin
          rec_on = 1'b0;
          ended = 1'b1;
        end
        video_tally = 0;
      end
      has_frame = 1'b1;
      res.rate = RATE_W'(rate_hold);
      res.rec = rec_on;
      res.started = started;
      res.ended = ended;
      res.cooldown = CD_W'(cooldown_ctr);
      res.frames = TALLY_W'(video_tally);
    end
  endtask

  function automatic stim_row_t pix_row(input int c_b, c_g, c_r, o_b, o_g, o_r,
                                        input bit ok, input bit last, input int unsigned reps);
    stim_row_t r;
    r.kind = ROW_PIXEL;
    r.reg_idx = '0;
    r.reg_data = '0;
    r.pix = '{PIX_W'(c_b), PIX_W'(c_g), PIX_W'(c_r), PIX_W'(o_b), PIX_W'(o_g), PIX_W'(o_r),
              ok, last};
    r.reps = reps;
    r.typed = 1'b0;
    r.res = '0;
    return r;
  endfunction

  function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input int value);
    stim_row_t r;
    r = pix_row(0, 0, 0, 0, 0, 0, 1'b0, 1'b0, 1);
    r.kind = ROW_REG;
    r.reg_idx = idx;
    r.reg_data = CFG_DATA_W'(value);
    return r;
  endfunction

  function automatic stim_row_t with_result(input stim_row_t r, input int rate, input bit rec,
                                            input bit st, input bit en, input int cd,
                                            input int vf);
    r.typed = 1'b1;
    r.res = '{RATE_W'(rate), rec, st, en, CD_W'(cd), TALLY_W'(vf)};
    return r;
  endfunction

  function automatic int unsigned idle_gap();
    if (calm || $urandom_range(4, 0) != 0) return 0;
    return $urandom_range(13, 1);
  endfunction

  function automatic logic [PIX_W-1:0] nudge(input logic [PIX_W-1:0] c);
    int t;
    t = int'(c) + int'($urandom_range(140, 0)) - 70;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return PIX_W'(t);
  endfunction

  // valid stays high after the beat so back-to-back pixels need one assignment per step
  task automatic send_pixel(input pixel_t p, input bit typed, input frame_res_t typed_res,
                            input bit steady);
    int unsigned gap;
    bit has_frame;
    frame_res_t res;
    gap = steady ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cur_blue_i <= p.cur_b;
    cur_green_i <= p.cur_g;
    cur_red_i <= p.cur_r;
    old_blue_i <= p.old_b;
    old_green_i <= p.old_g;
    old_red_i <= p.old_r;
    old_valid_i <= p.old_ok;
    last_pixel_i <= p.last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    track_pixel(p, has_frame, res);
    if (has_frame) expected_frames.push_back(typed ? typed_res : res);
    pixels_sent++;
  endtask

  // caller lowers cfg_valid_i once a run of writes is over
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_PIXEL_THRESHOLD: cfg_thr = data[PIX_W-1:0];
      CFG_RATE_LOWER:      cfg_lower = int'($signed(data[RATE_W-1:0]));
      CFG_RATE_UPPER:      cfg_upper = int'($signed(data[RATE_W-1:0]));
      CFG_DIFF_INTERVAL:   cfg_interval = data[PHASE_W-1:0];
      CFG_FRAMES_AFTER:    cfg_hold = data[15:0];
      CFG_MAX_FRAMES:      cfg_max = data[TALLY_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_settings(input trigger_cfg_t s);
    write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom));
    write_reg(CFG_PIXEL_THRESHOLD, CFG_DATA_W'(s.thr));
    write_reg(CFG_RATE_LOWER, CFG_DATA_W'(s.lower));
    write_reg(CFG_RATE_UPPER, CFG_DATA_W'(s.upper));
    write_reg(CFG_DIFF_INTERVAL, CFG_DATA_W'(s.interval));
    write_reg(CFG_FRAMES_AFTER, CFG_DATA_W'(s.hold_frames));
    write_reg(CFG_MAX_FRAMES, CFG_DATA_W'(s.max_frames));
    write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  function automatic trigger_cfg_t pick_settings(input int unsigned ph);
    trigger_cfg_t s;
    if (ph == 0) begin
      s = '{8'd0, -100, 10000, 16'd1, 16'd0, 24'd1};
    end else if (ph == 1) begin
      s = '{8'd255, -100, 10000, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF};
    end else begin
      s.thr = PIX_W'($urandom_range(90, 10));
      s.lower = int'($urandom_range(6100, 0)) - 100;
      s.upper = s.lower + int'($urandom_range(10000, 300));
      if (s.upper > 10000) s.upper = 10000;
      s.interval = PHASE_W'($urandom_range(3, 1));
      s.hold_frames = 16'($urandom_range(8, 0));
      s.max_frames = TALLY_W'($urandom_range(12, 1));
    end
    return s;
  endfunction

  // mostly short frames so frame ends pile up behind the divider
  task automatic send_frame();
    int unsigned len, pct;
    bit broken;
    pixel_t p;
    len = ($urandom_range(9, 0) < 8) ? $urandom_range(6, 1) : $urandom_range(40, 7);
    pct = $urandom_range(100, 0);
    broken = ($urandom_range(7, 0) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      p.cur_b = PIX_W'($urandom);
      p.cur_g = PIX_W'($urandom);
      p.cur_r = PIX_W'($urandom);
      if ($urandom_range(99, 0) < pct) begin
        p.old_b = PIX_W'($urandom);
        p.old_g = PIX_W'($urandom);
        p.old_r = PIX_W'($urandom);
      end else begin
        p.old_b = nudge(p.cur_b);
        p.old_g = nudge(p.cur_g);
        p.old_r = nudge(p.cur_r);
      end
      p.old_ok = !(broken && $urandom_range(2, 0) == 0);
      p.last = (i == len - 1);
      send_pixel(p, 1'b0, '0, 1'b0);
    end
  endtask

  task automatic compare_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    frame_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_frames.size() == 0) begin
        $display("%0t: result beat with nothing pending, rate %0d", $time, change_rate_o);
        fail_count++;
      end else begin
        want = expected_frames.pop_front();
        compare_field("change_rate", $signed(want.rate), change_rate_o);
        compare_field("recording", want.rec, recording_o);
        compare_field("record_started", want.started, record_started_o);
        compare_field("record_ended", want.ended, record_ended_o);
        compare_field("cooldown_left", $signed(want.cooldown), cooldown_left_o);
        compare_field("video_frames", want.frames, video_frames_o);
      end
      frames_checked++;
      if (record_started_o) starts_seen++;
      if (record_ended_o) ends_seen++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached, %0d frames still pending", $time,
               expected_frames.size());
      $display("tb_frame_difference_motion_trigger NOT OK");
      $finish;
    end
  end

  // result side: random stalls, one long hold on request, none once calm
  initial begin : sink
    int unsigned n;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
      end else if (!calm && $urandom_range(3, 0) == 0) begin
        out_ready_i <= 1'b0;
        n = $urandom_range(13, 1);
        repeat (n) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        n = $urandom_range(25, 1);
        repeat (n) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    stim_row_t rows[$];
    pixel_t p;
    bit cfg_open;
    int unsigned target;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: threshold 30, limits 0 and 10000, every frame, cooldown 64
    rows.push_back(with_result(pix_row(0, 0, 0, 0, 0, 0, 1, 1, 1), 0, 0, 0, 0, -1, 0));
    rows.push_back(with_result(pix_row(255, 255, 255, 0, 0, 0, 1, 1, 1),
                               10000, 0, 0, 0, -1, 0));
    rows.push_back(with_result(pix_row(0, 0, 0, 255, 255, 255, 0, 1, 1),
                               -100, 0, 0, 0, -1, 0));
    rows.push_back(pix_row(255, 0, 0, 0, 0, 0, 1, 0, 1));
    rows.push_back(with_result(pix_row(0, 255, 0, 0, 0, 0, 1, 1, 1), 5000, 1, 1, 0, 63, 1));
    // gray 30 then 31 around the threshold, previous pixel brighter
    rows.push_back(pix_row(0, 0, 0, 0, 51, 0, 1, 0, 1));
    rows.push_back(pix_row(0, 0, 0, 0, 52, 0, 1, 1, 1));
    // zero threshold, zero interval, one frame of cooldown
    rows.push_back(reg_row(CFG_PIXEL_THRESHOLD, 0));
    rows.push_back(reg_row(CFG_RATE_LOWER, -100));
    rows.push_back(reg_row(CFG_DIFF_INTERVAL, 0));
    rows.push_back(reg_row(CFG_FRAMES_AFTER, 1));
    rows.push_back(reg_row(CFG_MAX_FRAMES, 24'hFF_FFFF));
    rows.push_back(pix_row(10, 10, 10, 10, 10, 10, 1, 1, 1));
    rows.push_back(pix_row(11, 10, 10, 10, 10, 10, 1, 1, 1));
    rows.push_back(pix_row(0, 2, 255, 0, 0, 0, 1, 1, 1));
    // zero cooldown load, then a cap of one frame
    rows.push_back(reg_row(CFG_PIXEL_THRESHOLD, 255));
    rows.push_back(reg_row(CFG_DIFF_INTERVAL, 16'hFFFF));
    rows.push_back(reg_row(CFG_FRAMES_AFTER, 0));
    rows.push_back(reg_row(CFG_MAX_FRAMES, 1));
    rows.push_back(pix_row(255, 255, 255, 0, 0, 0, 1, 1, 1));
    rows.push_back(pix_row(0, 0, 0, 255, 255, 255, 1, 1, 1));
    rows.push_back(reg_row(CFG_DIFF_INTERVAL, 1));
    rows.push_back(reg_row(CFG_FRAMES_AFTER, 2));
    rows.push_back(pix_row(1, 2, 3, 4, 5, 6, 1, 1, 1));
    // limits at the top and bottom, nothing can trigger
    rows.push_back(reg_row(CFG_PIXEL_THRESHOLD, 30));
    rows.push_back(reg_row(CFG_RATE_LOWER, 10000));
    rows.push_back(reg_row(CFG_RATE_UPPER, -100));
    rows.push_back(reg_row(CFG_FRAMES_AFTER, 16'hFFFF));
    rows.push_back(pix_row(255, 255, 255, 0, 0, 0, 1, 1, 1));
    // narrow window around half change, a frame of exactly half changed pixels
    rows.push_back(reg_row(CFG_RATE_LOWER, 4999));
    rows.push_back(reg_row(CFG_RATE_UPPER, 5001));
    rows.push_back(reg_row(CFG_FRAMES_AFTER, 3));
    rows.push_back(reg_row(CFG_MAX_FRAMES, 65536));
    rows.push_back(pix_row(255, 255, 255, 0, 0, 0, 1, 0, 3));
    rows.push_back(pix_row(0, 0, 0, 0, 1, 0, 1, 0, 2));
    rows.push_back(pix_row(0, 0, 0, 0, 1, 0, 1, 1, 1));
    // previous frame missing for a single pixel in mid frame
    rows.push_back(pix_row(9, 9, 9, 9, 9, 9, 1, 0, 1));
    rows.push_back(pix_row(9, 9, 9, 200, 9, 9, 0, 0, 1));
    rows.push_back(pix_row(9, 9, 9, 9, 9, 9, 1, 1, 1));

    cfg_open = 1'b0;
    for (int k = 0; k < rows.size(); k++) begin
      if (rows[k].kind == ROW_REG) begin
        if (!cfg_open) begin
          wait_drained();
          cfg_open = 1'b1;
        end
        write_reg(rows[k].reg_idx, rows[k].reg_data);
      end else begin
        if (cfg_open) begin
          cfg_valid_i <= 1'b0;
          cfg_open = 1'b0;
        end
        for (int unsigned n = 0; n < rows[k].reps; n++) begin
          p = rows[k].pix;
          p.last = rows[k].pix.last && (n == rows[k].reps - 1);
          send_pixel(p, rows[k].typed, rows[k].res, rows[k].reps > 1);
        end
      end
    end

    target = pixels_sent;
    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      wait_drained();
      apply_settings(pick_settings(ph));
      calm = (ph == RAND_PHASES - 1);
      if (ph == 2) long_hold_req = 1'b1;
      target += RAND_ITEMS / RAND_PHASES;
      while (pixels_sent < target) send_frame();
    end

    wait_drained();
    $display("sent %0d pixels and %0d register writes; checked %0d frame results",
             pixels_sent, reg_writes, frames_checked);
    $display("recordings started %0d times and ended %0d times", starts_seen, ends_seen);
    if (fail_count == 0) begin
      $display("tb_frame_difference_motion_trigger OK");
    end else begin
      $display("tb_frame_difference_motion_trigger NOT OK");
    end
    $finish;
  end

endmodule
